@@ rtl/chm_pkg.sv @@
package chm_pkg;

	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int BUCKET_WAYS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int FUNC_W = 2;

	// Key bits folded into the bucket remainder per step, and steps per key
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = KEY_W / MOD_DIGIT;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_FIND,
		OP_SET,
		OP_REMOVE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	typedef struct packed {
		logic              found;
		logic [VAL_W-1:0]  read_value;
		logic              status;
	} res_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_READ,
		BK_EXEC
	} back_state_t;

	function automatic op_t classify(input logic [FUNC_W-1:0] func);
		op_t op;
		case (func)
			FUNC_FIND:   op = OP_FIND;
			FUNC_SET:    op = OP_SET;
			FUNC_REMOVE: op = OP_REMOVE;
			default:     op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

@@ rtl/chained_hash_map_engine.sv @@
// Key-to-value map with bounded chaining: bucket = key mod NUM_BUCKETS, BUCKET_WAYS
// slots per bucket. Pulse start with func/key/value while busy is low; every command
// gives exactly one result, shown for one cycle with done high, which the receiver
// must take then. After reset the engine sweeps the valid bits, one bucket row a
// cycle, and holds busy high until the sweep is done. The back end reads a whole
// bucket row in its READ state and compares and writes it back in the next cycle,
// in EXEC; done rises in the cycle after EXEC. With a power-of-two bucket
// count the front end takes the key straight into a 2-entry queue, so commands can
// be started every cycle until the queue fills; the back end pops one command per
// READ and EXEC pass. For any other bucket count the front end reduces the key 4
// bits a cycle and keeps busy high until the reduced command is pushed.
module chained_hash_map_engine #(
	parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF,
	parameter int BUCKET_WAYS = chm_pkg::BUCKET_WAYS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [chm_pkg::FUNC_W-1:0] func,
	input  logic [chm_pkg::KEY_W-1:0]  key,
	input  logic [chm_pkg::VAL_W-1:0]  value,
	output logic                       done,
	output logic                       found,
	output logic [chm_pkg::VAL_W-1:0]  read_value,
	output logic                       status
);

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int QW    = BKT_W + chm_pkg::CMD_W;

	logic             q_full, q_empty, q_wr, q_rd, clearing;
	chm_pkg::cmd_t    wr_cmd, head_cmd;
	logic [BKT_W-1:0] wr_bucket, head_bucket;
	logic [QW-1:0]    q_wdata, q_rdata;
	chm_pkg::res_t    res;

	chm_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.key         (key),
		.value       (value),
		.hold        (clearing),
		.full        (q_full),
		.busy        (busy),
		.push        (q_wr),
		.push_cmd    (wr_cmd),
		.push_bucket (wr_bucket)
	);

	assign q_wdata = {wr_bucket, wr_cmd};

	chm_fifo #(.WIDTH(QW), .DEPTH(chm_pkg::QUEUE_DEPTH_DEF)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	assign head_cmd    = q_rdata[chm_pkg::CMD_W-1:0];
	assign head_bucket = q_rdata[QW-1:chm_pkg::CMD_W];

	chm_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_WAYS(BUCKET_WAYS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.head_cmd    (head_cmd),
		.head_bucket (head_bucket),
		.pop         (q_rd),
		.clearing    (clearing),
		.done        (done),
		.res         (res)
	);

	assign found      = res.found;
	assign read_value = res.read_value;
	assign status     = res.status;

endmodule

@@ rtl/chm_ram.sv @@
module chm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/chm_fifo.sv @@
module chm_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = chm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full && !rd))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && empty))
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

@@ rtl/chm_front.sv @@
module chm_front #(
	parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               start,
	input  logic [chm_pkg::FUNC_W-1:0]                         func,
	input  logic [chm_pkg::KEY_W-1:0]                          key,
	input  logic [chm_pkg::VAL_W-1:0]                          value,
	input  logic                                               hold,
	input  logic                                               full,
	output logic                                               busy,
	output logic                                               push,
	output chm_pkg::cmd_t                                      push_cmd,
	output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] push_bucket
);

	localparam int  BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam bit  POW2  = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			logic [chm_pkg::KEY_W-1:0] masked;

			// Bucket is the low key bits
			assign masked      = key & chm_pkg::KEY_W'(NUM_BUCKETS - 1);
			assign busy        = full | hold;
			assign push        = start & ~busy;
			assign push_cmd    = '{op: chm_pkg::classify(func), key: key, value: value};
			assign push_bucket = masked[BKT_W-1:0];
		end else begin : g_mod
			localparam int RW = BKT_W + 1;
			localparam logic [RW-1:0] NB = RW'(NUM_BUCKETS);

			logic                              pend_q, rdy_q;
			logic [chm_pkg::MOD_CNT_W-1:0]     cnt_q;
			logic [chm_pkg::KEY_W-1:0]         sh_q;
			logic [RW-1:0]                     rem_q, rem_d;
			chm_pkg::cmd_t                     cmd_q;
			logic                              accept;

			assign busy        = pend_q | hold;
			assign accept      = start & ~busy;
			assign push        = rdy_q & ~full;
			assign push_cmd    = cmd_q;
			assign push_bucket = rem_q[BKT_W-1:0];

			// Fold the next key digit into the remainder, MSB first
			always_comb begin
				logic [RW-1:0] r;
				logic [RW-1:0] t;
				r = rem_q;
				for (int i = 0; i < chm_pkg::MOD_DIGIT; i++) begin
					t = {r[RW-2:0], sh_q[chm_pkg::KEY_W-1-i]};
					r = (t >= NB) ? t - NB : t;
				end
				rem_d = r;
			end

			always_ff @(posedge clk) begin
				if (accept) begin
					cmd_q <= '{op: chm_pkg::classify(func), key: key, value: value};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pend_q <= 1'b0;
					rdy_q  <= 1'b0;
					cnt_q  <= '0;
					sh_q   <= '0;
					rem_q  <= '0;
				end else if (accept) begin
					pend_q <= 1'b1;
					rdy_q  <= 1'b0;
					cnt_q  <= '0;
					sh_q   <= key;
					rem_q  <= '0;
				end else if (pend_q && !rdy_q) begin
					rem_q <= rem_d;
					sh_q  <= sh_q << chm_pkg::MOD_DIGIT;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == chm_pkg::MOD_CNT_W'(chm_pkg::MOD_STEPS - 1)) begin
						rdy_q <= 1'b1;
					end
				end else if (push) begin
					pend_q <= 1'b0;
					rdy_q  <= 1'b0;
				end
			end
		end
	endgenerate

endmodule

@@ rtl/chm_back.sv @@
module chm_back #(
	parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF,
	parameter int BUCKET_WAYS = chm_pkg::BUCKET_WAYS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               empty,
	input  chm_pkg::cmd_t                                      head_cmd,
	input  logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] head_bucket,
	output logic                                               pop,
	output logic                                               clearing,
	output logic                                               done,
	output chm_pkg::res_t                                      res
);

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int KROW  = BUCKET_WAYS * chm_pkg::KEY_W;
	localparam int VROW  = BUCKET_WAYS * chm_pkg::VAL_W;

	chm_pkg::back_state_t state_q, state_d;
	logic [BKT_W-1:0]     clr_q;
	chm_pkg::cmd_t        cmd_q;
	logic [BKT_W-1:0]     bucket_q;
	logic                 done_q;
	chm_pkg::res_t        res_q, res_d;

	logic [KROW-1:0]        key_rd, key_wd;
	logic [VROW-1:0]        val_rd, val_wd;
	logic [BUCKET_WAYS-1:0] vld_rd, vld_wd;
	logic                   key_we, val_we, vld_we;
	logic [BKT_W-1:0]       vld_waddr;

	logic [BUCKET_WAYS-1:0] hit, hit_oh, free, free_oh, sel_oh;
	logic                   any_hit, any_free, is_find, is_set, is_rem;
	logic [chm_pkg::VAL_W-1:0] hit_val;

	chm_ram #(.WIDTH(KROW), .DEPTH(NUM_BUCKETS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (bucket_q),
		.wdata (key_wd),
		.re    (pop),
		.raddr (head_bucket),
		.rdata (key_rd)
	);

	chm_ram #(.WIDTH(VROW), .DEPTH(NUM_BUCKETS)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (bucket_q),
		.wdata (val_wd),
		.re    (pop),
		.raddr (head_bucket),
		.rdata (val_rd)
	);

	chm_ram #(.WIDTH(BUCKET_WAYS), .DEPTH(NUM_BUCKETS)) u_vld_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wd),
		.re    (pop),
		.raddr (head_bucket),
		.rdata (vld_rd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			chm_pkg::BK_CLEAR: begin
				if (clr_q == BKT_W'(NUM_BUCKETS - 1)) begin
					state_d = chm_pkg::BK_READ;
				end
			end
			chm_pkg::BK_READ: begin
				if (!empty) begin
					state_d = chm_pkg::BK_EXEC;
				end
			end
			chm_pkg::BK_EXEC: state_d = chm_pkg::BK_READ;
			default:          state_d = chm_pkg::BK_CLEAR;
		endcase
	end

	// State outputs
	always_comb begin
		pop      = 1'b0;
		clearing = 1'b0;
		case (state_q)
			chm_pkg::BK_CLEAR: clearing = 1'b1;
			chm_pkg::BK_READ:  pop      = !empty;
			chm_pkg::BK_EXEC:  pop      = 1'b0;
			default:           clearing = 1'b1;
		endcase
	end

	// Bucket compare on the row read last cycle
	always_comb begin
		is_find = (cmd_q.op == chm_pkg::OP_FIND);
		is_set  = (cmd_q.op == chm_pkg::OP_SET);
		is_rem  = (cmd_q.op == chm_pkg::OP_REMOVE);
		for (int w = 0; w < BUCKET_WAYS; w++) begin
			hit[w] = vld_rd[w] && (key_rd[w*chm_pkg::KEY_W +: chm_pkg::KEY_W] == cmd_q.key);
		end
		free     = ~vld_rd;
		hit_oh   = hit & (~hit + 1'b1);
		free_oh  = free & (~free + 1'b1);
		any_hit  = |hit;
		any_free = |free;
		sel_oh   = any_hit ? hit_oh : free_oh;
		hit_val  = '0;
		for (int w = 0; w < BUCKET_WAYS; w++) begin
			hit_val = hit_val | ({chm_pkg::VAL_W{hit_oh[w]}} &
				val_rd[w*chm_pkg::VAL_W +: chm_pkg::VAL_W]);
			key_wd[w*chm_pkg::KEY_W +: chm_pkg::KEY_W] = free_oh[w] ? cmd_q.key :
				key_rd[w*chm_pkg::KEY_W +: chm_pkg::KEY_W];
			val_wd[w*chm_pkg::VAL_W +: chm_pkg::VAL_W] = sel_oh[w] ? cmd_q.value :
				val_rd[w*chm_pkg::VAL_W +: chm_pkg::VAL_W];
		end
	end

	always_comb begin
		logic exec;
		exec      = (state_q == chm_pkg::BK_EXEC);
		key_we    = exec && is_set && !any_hit && any_free;
		val_we    = exec && is_set && (any_hit || any_free);
		vld_we    = clearing || key_we || (exec && is_rem && any_hit);
		vld_waddr = clearing ? clr_q : bucket_q;
		if (clearing) begin
			vld_wd = '0;
		end else if (is_set) begin
			vld_wd = vld_rd | free_oh;
		end else begin
			vld_wd = vld_rd & ~hit_oh;
		end
		res_d.found      = any_hit && (is_find || is_set || is_rem);
		res_d.read_value = (is_find && any_hit) ? hit_val : '0;
		res_d.status     = is_set && !any_hit && !any_free;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q    <= head_cmd;
			bucket_q <= head_bucket;
		end
		if (state_q == chm_pkg::BK_EXEC) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chm_pkg::BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == chm_pkg::BK_EXEC);
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == chm_pkg::BK_EXEC))
		else $error("result strobe without an executed command");

	a_drop_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status) |-> !res_q.found)
		else $error("dropped set reported a hit");

	a_pop_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == chm_pkg::BK_EXEC))
		else $error("popped command not executed next cycle");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("command popped during valid clear");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int NB          = chm_pkg::NUM_BUCKETS_DEF;
	localparam int WAYS        = chm_pkg::BUCKET_WAYS_DEF;
	localparam int SLOTS       = NB * WAYS;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [chm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [chm_pkg::FUNC_W-1:0]  func;
	logic [chm_pkg::KEY_W-1:0]   key;
	logic [chm_pkg::VAL_W-1:0]   value;
	logic                        done;
	logic                        found;
	logic [chm_pkg::VAL_W-1:0]   read_value;
	logic                        status;

	chained_hash_map_engine #(
		.NUM_BUCKETS(NB),
		.BUCKET_WAYS(WAYS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.key        (key),
		.value      (value),
		.done       (done),
		.found      (found),
		.read_value (read_value),
		.status     (status)
	);

	// Shadow copy of the map contents
	logic [chm_pkg::KEY_W-1:0] shadow_key   [SLOTS];
	logic [chm_pkg::VAL_W-1:0] shadow_value [SLOTS];
	bit                        shadow_valid [SLOTS];

	chm_pkg::res_t pending_results[$];

	int unsigned cycle_count;
	int          err_count;
	int          beats_sent;
	int          results_checked;
	int          hit_count;
	int          drop_count;
	int          idle_pct;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [chm_pkg::VAL_W-1:0] got,
			input logic [chm_pkg::VAL_W-1:0] exp);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
		err_count++;
	endtask

	// Apply one command to the shadow map and return the result it should give
	function automatic chm_pkg::res_t map_apply(input logic [chm_pkg::FUNC_W-1:0] f,
			input logic [chm_pkg::KEY_W-1:0] k, input logic [chm_pkg::VAL_W-1:0] v);
		chm_pkg::res_t r;
		int   base;
		int   hit;
		int   free_slot;
		r = '0;
		base = (k % NB) * WAYS;
		hit = -1;
		free_slot = -1;
		if (f == FUNC_UNUSED)
			return r;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (shadow_valid[base + w] && shadow_key[base + w] == k)
				hit = w;
			if (!shadow_valid[base + w])
				free_slot = w;
		end
		r.found = (hit >= 0);
		case (f)
			chm_pkg::FUNC_FIND: begin
				if (hit >= 0)
					r.read_value = shadow_value[base + hit];
			end
			chm_pkg::FUNC_SET: begin
				if (hit >= 0) begin
					shadow_value[base + hit] = v;
				end else if (free_slot >= 0) begin
					shadow_key[base + free_slot] = k;
					shadow_value[base + free_slot] = v;
					shadow_valid[base + free_slot] = 1'b1;
				end else begin
					r.status = 1'b1;
				end
			end
			chm_pkg::FUNC_REMOVE: begin
				if (hit >= 0)
					shadow_valid[base + hit] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Send one command beat, idling the sender at random beforehand
	task automatic send_cmd(input logic [chm_pkg::FUNC_W-1:0] f,
			input logic [chm_pkg::KEY_W-1:0] k, input logic [chm_pkg::VAL_W-1:0] v);
		chm_pkg::res_t r;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		func  <= f;
		key   <= k;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		r = map_apply(f, k, v);
		if (r.found)
			hit_count++;
		if (r.status)
			drop_count++;
		pending_results = {pending_results, r};
		beats_sent++;
	endtask

	always @(posedge clk) begin
		chm_pkg::res_t exp;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", read_value, '0);
			end else begin
				exp = pending_results.pop_front();
				if (found !== exp.found)
					report_mismatch("found", found, exp.found);
				if (read_value !== exp.read_value)
					report_mismatch("read_value", read_value, exp.read_value);
				if (status !== exp.status)
					report_mismatch("status", status, exp.status);
				results_checked++;
			end
		end
	end

	task automatic test_extremes();
		send_cmd(chm_pkg::FUNC_FIND, '0, '0);
		send_cmd(chm_pkg::FUNC_SET, '0, '1);
		send_cmd(chm_pkg::FUNC_FIND, '0, '0);
		send_cmd(chm_pkg::FUNC_SET, '1, '0);
		send_cmd(chm_pkg::FUNC_FIND, '1, '1);
	endtask

	task automatic test_update();
		send_cmd(chm_pkg::FUNC_SET, '0, 32'h1234_5678);
		send_cmd(chm_pkg::FUNC_FIND, '0, '0);
	endtask

	// Fill one bucket, then overflow it; the ninth key must be dropped
	task automatic test_bucket_full();
		for (int i = 1; i <= WAYS + 1; i++)
			send_cmd(chm_pkg::FUNC_SET, 5 + NB * i, 32'hA000_0000 + i);
		send_cmd(chm_pkg::FUNC_FIND, 5 + NB * (WAYS + 1), '0);
	endtask

	task automatic test_remove_and_reuse();
		send_cmd(chm_pkg::FUNC_REMOVE, 5 + NB * 3, '0);
		send_cmd(chm_pkg::FUNC_REMOVE, 5 + NB * 3, '0);
		send_cmd(chm_pkg::FUNC_SET, 5 + NB * (WAYS + 1), 32'h5A5A_A5A5);
		send_cmd(chm_pkg::FUNC_FIND, 5 + NB * 3, '0);
		send_cmd(chm_pkg::FUNC_FIND, 5 + NB * (WAYS + 1), '0);
	endtask

	task automatic test_unused_code();
		send_cmd(FUNC_UNUSED, '0, '1);
		send_cmd(chm_pkg::FUNC_FIND, '0, '0);
	endtask

	// Mostly traffic on a small pool of colliding keys, some fully random keys
	task automatic test_random_mix(input int pct, input int count);
		logic [chm_pkg::KEY_W-1:0] key_pool[$];
		logic [chm_pkg::KEY_W-1:0] k;
		logic [chm_pkg::FUNC_W-1:0] f;
		int unsigned bucket;
		int unsigned pick;
		idle_pct = pct;
		for (int b = 0; b < 3; b++) begin
			bucket = (b == 0) ? 0 : (b == 1) ? NB - 1 : $urandom_range(NB - 1);
			for (int i = 0; i < WAYS + 4; i++) begin
				k = $urandom();
				k = k - (k % NB) + bucket;
				key_pool = {key_pool, k};
			end
		end
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35)
				f = chm_pkg::FUNC_FIND;
			else if (pick < 70)
				f = chm_pkg::FUNC_SET;
			else if (pick < 92)
				f = chm_pkg::FUNC_REMOVE;
			else
				f = FUNC_UNUSED;
			if ($urandom_range(99) < 75)
				k = key_pool[$urandom_range(key_pool.size() - 1)];
			else
				k = $urandom();
			send_cmd(f, k, $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		func   = '0;
		key    = '0;
		value  = '0;
		cycle_count = 0;
		err_count = 0;
		beats_sent = 0;
		results_checked = 0;
		hit_count = 0;
		drop_count = 0;
		idle_pct = 0;
		for (int s = 0; s < SLOTS; s++) begin
			shadow_key[s]   = '0;
			shadow_value[s] = '0;
			shadow_valid[s] = 1'b0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 27;
		test_extremes();
		test_update();
		test_bucket_full();
		test_remove_and_reuse();
		test_unused_code();
		test_random_mix(27, 130);
		test_random_mix(49, 130);
		test_random_mix(0, 130);

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d commands, checked %0d results", beats_sent, results_checked);
		$display("key hits %0d, full-bucket drops %0d, mismatches %0d", hit_count, drop_count,
			err_count);
		if (err_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/chm_fifo.sv
rtl/chm_front.sv
rtl/chm_back.sv
rtl/chained_hash_map_engine.sv
test/tb.sv
